[src/crp_pkg.sv]
package crp_pkg;

   // record layout
   localparam int HASH_BYTES  = 20;
   localparam int MAX_PARENTS = 8;
   localparam int TIME_BYTES  = 8;

   // configuration port
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic [0:0] REG_EXPECTED_VERSION = 1'b0;
   localparam logic [7:0] EXPECTED_VERSION_RESET = 8'd2;

   // parse phase, also the byte class reported on the result
   typedef enum logic [3:0] {
      PH_VERSION   = 4'd0,
      PH_COUNT     = 4'd1,
      PH_PHASH     = 4'd2,
      PH_CATALOG   = 4'd3,
      PH_TIME      = 4'd4,
      PH_NAME_LEN  = 4'd5,
      PH_NAME_TEXT = 4'd6,
      PH_MAIL_LEN  = 4'd7,
      PH_MAIL_TEXT = 4'd8,
      PH_MSG_LEN   = 4'd9,
      PH_MSG_TEXT  = 4'd10,
      PH_DONE      = 4'd11
   } phase_type;

endpackage

[src/crp_if.sv]
interface crp_req_if;
   import crp_pkg::*;

   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last_byte;

   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface crp_rsp_if;
   import crp_pkg::*;

   logic        valid;
   logic        ready;
   logic [3:0]  byte_class;
   logic [7:0]  parent_number;
   logic [15:0] field_offset;
   logic [7:0]  byte_value;
   logic        record_end;
   logic        record_status;

   modport source (output valid, output byte_class, output parent_number,
                   output field_offset, output byte_value, output record_end,
                   output record_status, input ready);
   modport sink (input valid, input byte_class, input parent_number,
                 input field_offset, input byte_value, input record_end,
                 input record_status, output ready);
endinterface

[src/commit_record_parser.sv]
// Commit record parser. Record bytes arrive one per request on req_bus, the
// final byte flagged by last_byte; each request yields exactly one result on
// rsp_bus with the byte's field class, parent number, offset within its field,
// the byte itself, and on the final byte the ok/corrupt status. A small phase
// register and its counters decide each byte combinationally, and the result
// sits in an output register, so one request is taken every cycle while rsp_bus
// keeps up; the result appears in the cycle after its request is taken. A record
// is corrupt when its version byte differs from expected_version (APB register
// at byte address 0, reset value 2), when its parent count exceeds the maximum,
// or when it ends before the message text is complete. Bytes after a complete
// record or after an error are reported as ignored.
module commit_record_parser (
   input  logic                             clock,
   input  logic                             reset,
   crp_req_if.sink                          req_bus,
   crp_rsp_if.source                        rsp_bus,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [crp_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [crp_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [crp_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                             pready
);
   import crp_pkg::*;

   // configuration
   logic [7:0] expected_version_ff;

   // parse state
   phase_type   phase_ff, phase_in;
   logic [15:0] offset_ff, offset_in;
   logic [7:0]  parents_total_ff, parents_total_in;
   logic [7:0]  parent_index_ff, parent_index_in;
   logic [15:0] string_length_ff, string_length_in;
   logic        error_ff, error_in;

   // result register
   logic        rsp_valid_ff;
   logic [3:0]  byte_class_ff, byte_class_in;
   logic [7:0]  parent_number_ff, parent_number_in;
   logic [15:0] field_offset_ff, field_offset_in;
   logic [7:0]  byte_value_ff;
   logic        record_end_ff;
   logic        record_status_ff, record_status_in;

   logic        req_fire;
   logic [15:0] offset_inc;
   logic [7:0]  parent_index_inc;
   logic [7:0]  in_byte;
   logic        csr_write;

   // apb register access
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && (paddr[2] == REG_EXPECTED_VERSION);
   assign prdata    = (paddr[2] == REG_EXPECTED_VERSION) ?
                      {{(CSR_DATA_W-8){1'b0}}, expected_version_ff} : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         expected_version_ff <= EXPECTED_VERSION_RESET;
      end else if (csr_write) begin
         expected_version_ff <= pwdata[7:0];
      end
   end

   // take a request whenever the result register is free or being emptied
   assign req_bus.ready = !rsp_valid_ff || rsp_bus.ready;
   assign req_fire      = req_bus.valid && req_bus.ready;
   assign in_byte       = req_bus.data_byte;

   assign offset_inc       = offset_ff + 16'd1;
   assign parent_index_inc = parent_index_ff + 8'd1;

   // per-byte decision and next parse state
   always_comb begin
      phase_in          = phase_ff;
      offset_in         = offset_ff;
      parents_total_in  = parents_total_ff;
      parent_index_in   = parent_index_ff;
      string_length_in  = string_length_ff;
      error_in          = error_ff;
      byte_class_in     = phase_ff;
      parent_number_in  = '0;
      field_offset_in   = '0;
      record_status_in  = 1'b0;

      unique case (phase_ff)
         PH_VERSION: begin
            if (in_byte != expected_version_ff) begin
               error_in = 1'b1;
               phase_in = PH_DONE;
            end else begin
               phase_in = PH_COUNT;
            end
         end
         PH_COUNT: begin
            if (in_byte > 8'(MAX_PARENTS)) begin
               error_in = 1'b1;
               phase_in = PH_DONE;
            end else begin
               parents_total_in = in_byte;
               parent_index_in  = '0;
               offset_in        = '0;
               phase_in         = (in_byte != 8'd0) ? PH_PHASH : PH_CATALOG;
            end
         end
         PH_PHASH: begin
            parent_number_in = parent_index_ff;
            field_offset_in  = offset_ff;
            offset_in        = offset_inc;
            if (offset_inc >= 16'(HASH_BYTES)) begin
               offset_in       = '0;
               parent_index_in = parent_index_inc;
               if (parent_index_inc >= parents_total_ff) begin
                  phase_in = PH_CATALOG;
               end
            end
         end
         PH_CATALOG: begin
            field_offset_in = offset_ff;
            offset_in       = offset_inc;
            if (offset_inc >= 16'(HASH_BYTES)) begin
               offset_in = '0;
               phase_in  = PH_TIME;
            end
         end
         PH_TIME: begin
            field_offset_in = offset_ff;
            offset_in       = offset_inc;
            if (offset_inc >= 16'(TIME_BYTES)) begin
               offset_in = '0;
               phase_in  = PH_NAME_LEN;
            end
         end
         PH_NAME_LEN, PH_MAIL_LEN, PH_MSG_LEN: begin
            field_offset_in = offset_ff;
            if (offset_ff == 16'd0) begin
               string_length_in = {8'd0, in_byte};
               offset_in        = 16'd1;
            end else begin
               string_length_in = {in_byte, 8'd0} | string_length_ff;
               offset_in        = '0;
               // an empty string skips its text field
               if (string_length_in != 16'd0) begin
                  phase_in = phase_type'(phase_ff + 4'd1);
               end else if (phase_ff == PH_MSG_LEN) begin
                  phase_in = PH_DONE;
               end else begin
                  phase_in = phase_type'(phase_ff + 4'd2);
               end
            end
         end
         PH_NAME_TEXT, PH_MAIL_TEXT, PH_MSG_TEXT: begin
            field_offset_in = offset_ff;
            offset_in       = offset_inc;
            if (offset_inc >= string_length_ff) begin
               offset_in = '0;
               phase_in  = (phase_ff == PH_MSG_TEXT) ? PH_DONE :
                           phase_type'(phase_ff + 4'd1);
            end
         end
         default: begin
            byte_class_in = PH_DONE;
         end
      endcase

      // final byte reports status and rearms for the next record
      if (req_bus.last_byte) begin
         record_status_in = error_in || (phase_in != PH_DONE);
         phase_in         = PH_VERSION;
         offset_in        = '0;
         parents_total_in = '0;
         parent_index_in  = '0;
         string_length_in = '0;
         error_in         = 1'b0;
      end
   end

   // parse state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= PH_VERSION;
         offset_ff        <= '0;
         parents_total_ff <= '0;
         parent_index_ff  <= '0;
         string_length_ff <= '0;
         error_ff         <= 1'b0;
      end else if (req_fire) begin
         phase_ff         <= phase_in;
         offset_ff        <= offset_in;
         parents_total_ff <= parents_total_in;
         parent_index_ff  <= parent_index_in;
         string_length_ff <= string_length_in;
         error_ff         <= error_in;
      end
   end

   // result valid
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (req_fire) begin
         byte_class_ff    <= byte_class_in;
         parent_number_ff <= parent_number_in;
         field_offset_ff  <= field_offset_in;
         byte_value_ff    <= in_byte;
         record_end_ff    <= req_bus.last_byte;
         record_status_ff <= record_status_in;
      end
   end

   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.byte_class    = byte_class_ff;
   assign rsp_bus.parent_number = parent_number_ff;
   assign rsp_bus.field_offset  = field_offset_ff;
   assign rsp_bus.byte_value    = byte_value_ff;
   assign rsp_bus.record_end    = record_end_ff;
   assign rsp_bus.record_status = record_status_ff;

endmodule
